// ----- rtl/core/hmt_pkg.sv -----
package hmt_pkg;

   // message kinds carried in the op field
   typedef enum logic [1:0] {
      OP_JOIN_REQ = 2'd0,
      OP_JOIN_REP = 2'd1,
      OP_GOSSIP   = 2'd2,
      OP_TICK     = 2'd3
   } hmt_op_type;

   // configuration register indexes
   typedef enum logic {
      CSR_OWN_ADDRESS    = 1'b0,
      CSR_REMOVE_TIMEOUT = 1'b1
   } hmt_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_FINISH
   } hmt_state_type;

   localparam int AddrW = 48;
   localparam int HbW   = 32;
   localparam int TimeW = 32;
   localparam int ToW   = 16;
   localparam int OutCntW = 7;

   localparam logic [AddrW-1:0] IntroducerAddr = 48'd1;
   localparam logic [ToW-1:0]   TimeoutReset   = 16'd20;
   localparam int               CountMax       = 127;

   // broadcast to every cell while a pass walks the chain
   typedef struct packed {
      logic [AddrW-1:0] addr;
      logic [HbW-1:0]   hb;
      logic [TimeW-1:0] now;
      logic [ToW-1:0]   timeout;
      logic             age_en;
      logic             insert;
   } hmt_key_type;

   // lookup status handed from cell to cell along with the token
   typedef struct packed {
      logic found;
      logic fresh;
      logic free_seen;
   } hmt_flags_type;

endpackage

// ----- rtl/core/hmt_cell.sv -----
module hmt_cell #(
   parameter int CNT_W = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hmt_pkg::hmt_key_type   key,
   input  logic                   tok_prev,
   input  hmt_pkg::hmt_flags_type flags_prev,
   input  logic [CNT_W-1:0]       removed_prev,
   output logic                   tok_out,
   output hmt_pkg::hmt_flags_type flags_out,
   output logic [CNT_W-1:0]       removed_out
);
   import hmt_pkg::*;

   logic             valid_ff, valid_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic [HbW-1:0]   hb_ff, hb_in;
   logic [TimeW-1:0] ts_ff, ts_in;
   logic             tok_ff;
   hmt_flags_type    flags_ff, flags_in;
   logic [CNT_W-1:0] removed_ff, removed_in;

   logic [TimeW-1:0] age;
   logic             aged, keep, match, fresher, scan_hit, ins_hit;

   always_comb begin
      age      = key.now - ts_ff;
      aged     = key.age_en && valid_ff && (age > {{(TimeW-ToW){1'b0}}, key.timeout});
      keep     = valid_ff && !aged;
      match    = keep && (addr_ff == key.addr);
      fresher  = key.hb > hb_ff;
      scan_hit = tok_prev && !key.insert;
      ins_hit  = tok_prev && key.insert && !valid_ff && !flags_prev.free_seen;

      valid_in   = valid_ff;
      addr_in    = addr_ff;
      hb_in      = hb_ff;
      ts_in      = ts_ff;
      flags_in   = flags_prev;
      removed_in = removed_prev;

      if (scan_hit) begin
         // drop stale entry, then look up the key among the survivors
         if (aged) begin
            valid_in   = 1'b0;
            removed_in = removed_prev + CNT_W'(1);
         end
         if (match) begin
            flags_in.found = 1'b1;
            if (fresher) begin
               hb_in          = key.hb;
               ts_in          = key.now;
               flags_in.fresh = 1'b1;
            end
         end
         if (!keep) begin
            flags_in.free_seen = 1'b1;
         end
      end

      // claim the lowest free slot
      if (ins_hit) begin
         valid_in           = 1'b1;
         addr_in            = key.addr;
         hb_in              = key.hb;
         ts_in              = key.now;
         flags_in.free_seen = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_prev;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      hb_ff      <= hb_in;
      ts_ff      <= ts_in;
      flags_ff   <= flags_in;
      removed_ff <= removed_in;
   end

   assign tok_out     = tok_ff;
   assign flags_out   = flags_ff;
   assign removed_out = removed_ff;

endmodule

// ----- rtl/core/heartbeat_membership_table.sv -----
// Channel  | Handshake              | Payload
// req      | req_valid / req_ready  | op, sender_address, message_heartbeat, current_time
// rsp      | rsp_valid / rsp_ready  | join reply, forward, removed, drop, count, in_group
// csr      | csr_we                 | csr_index, csr_wdata (no wait, no read-back)
//
// Walks: a lookup walks a token through TABLE_DEPTH cells, one cell a cycle; when a new
//   member is inserted, a second walk claims the lowest free slot. A join reply or a
//   tick outside the group walks no chain.
// Reset: clears every valid bit, the member count, own heartbeat and the joined flag.
// Stalls: the result register frees the core; the next item is taken while a result
//   waits, and a finished item holds in the last step until the result register frees.
module heartbeat_membership_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [hmt_pkg::AddrW-1:0]   req_sender_address,
   input  logic [hmt_pkg::HbW-1:0]     req_message_heartbeat,
   input  logic [hmt_pkg::TimeW-1:0]   req_current_time,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_send_join_reply,
   output logic                        rsp_forward_valid,
   output logic [hmt_pkg::AddrW-1:0]   rsp_forward_address,
   output logic [hmt_pkg::HbW-1:0]     rsp_forward_heartbeat,
   output logic [hmt_pkg::OutCntW-1:0] rsp_removed_count,
   output logic                        rsp_table_full_drop,
   output logic [hmt_pkg::OutCntW-1:0] rsp_member_count,
   output logic                        rsp_in_group,
   // configuration port
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [hmt_pkg::AddrW-1:0]   csr_wdata
);
   import hmt_pkg::*;

   localparam int CntW = $clog2(TABLE_DEPTH + 1);
   localparam int SatW = (CntW > OutCntW) ? CntW : OutCntW;

   // control state
   hmt_state_type    state_ff, state_in;
   logic             launch_ff, launch_in;
   logic             rsp_valid_ff;
   logic [CntW-1:0]  count_ff;
   logic             joined_ff;
   logic [HbW-1:0]   own_hb_ff;
   logic [AddrW-1:0] own_addr_ff;
   logic [ToW-1:0]   timeout_ff;

   // item key and partial result
   logic [AddrW-1:0] key_addr_ff;
   logic [HbW-1:0]   key_hb_ff;
   logic [TimeW-1:0] key_now_ff;
   logic             key_age_ff;
   logic             res_reply_ff;
   logic             res_fwd_ff;
   logic             res_drop_ff;
   logic [CntW-1:0]  res_removed_ff;

   // response register
   logic             rsp_reply_ff;
   logic             rsp_fwd_ff;
   logic [AddrW-1:0] rsp_faddr_ff;
   logic [HbW-1:0]   rsp_fhb_ff;
   logic [OutCntW-1:0] rsp_removed_ff;
   logic             rsp_drop_ff;
   logic [OutCntW-1:0] rsp_count_ff;
   logic             rsp_group_ff;

   // chain wiring
   logic             tok_w     [TABLE_DEPTH+1];
   hmt_flags_type    flags_w   [TABLE_DEPTH+1];
   logic [CntW-1:0]  removed_w [TABLE_DEPTH+1];
   hmt_key_type      key;

   logic             req_accept, in_group_now, is_tick, needs_scan;
   logic             tail_tok, insert_due, rsp_free;
   logic             scan_done, insert_done, rsp_load;
   logic [SatW-1:0]  rem_wide, cnt_wide;

   assign in_group_now = joined_ff || (own_addr_ff == IntroducerAddr);
   assign is_tick      = (req_op == OP_TICK);
   assign needs_scan   = (req_op == OP_JOIN_REQ) || (req_op == OP_GOSSIP) ||
                         (is_tick && in_group_now);
   assign req_accept   = req_valid && req_ready;
   assign tail_tok     = tok_w[TABLE_DEPTH];
   assign insert_due   = !flags_w[TABLE_DEPTH].found && flags_w[TABLE_DEPTH].free_seen;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   // key seen by every cell; insert pass only while in ST_INSERT
   always_comb begin
      key.addr    = key_addr_ff;
      key.hb      = key_hb_ff;
      key.now     = key_now_ff;
      key.timeout = timeout_ff;
      key.age_en  = key_age_ff;
      key.insert  = (state_ff == ST_INSERT);
   end

   // inject the token at the head of the chain
   assign tok_w[0]     = launch_ff;
   assign flags_w[0]   = '0;
   assign removed_w[0] = '0;

   for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      hmt_cell #(
         .CNT_W(CntW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .key         (key),
         .tok_prev    (tok_w[gi]),
         .flags_prev  (flags_w[gi]),
         .removed_prev(removed_w[gi]),
         .tok_out     (tok_w[gi+1]),
         .flags_out   (flags_w[gi+1]),
         .removed_out (removed_w[gi+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = needs_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (tail_tok) begin
               state_in = insert_due ? ST_INSERT : ST_FINISH;
            end
         end
         ST_INSERT: begin
            if (tail_tok) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready   = 1'b0;
      launch_in   = 1'b0;
      scan_done   = 1'b0;
      insert_done = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            launch_in = req_valid && needs_scan;
         end
         ST_SCAN: begin
            scan_done = tail_tok;
            launch_in = tail_tok && insert_due;
         end
         ST_INSERT: begin
            insert_done = tail_tok;
         end
         ST_FINISH: begin
            rsp_load = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         joined_ff    <= 1'b0;
         own_hb_ff    <= '0;
         own_addr_ff  <= '0;
         timeout_ff   <= TimeoutReset;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;

         // hold the result until taken; refill from the finished item
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            case (hmt_csr_type'(csr_index))
               CSR_OWN_ADDRESS:    own_addr_ff <= csr_wdata;
               CSR_REMOVE_TIMEOUT: timeout_ff  <= csr_wdata[ToW-1:0];
               default:            own_addr_ff <= own_addr_ff;
            endcase
         end

         if (req_accept) begin
            if (req_op == OP_JOIN_REP) begin
               joined_ff <= 1'b1;
            end
            // advance own heartbeat on a tick inside the group
            if (is_tick && in_group_now) begin
               own_hb_ff <= own_hb_ff + HbW'(1);
            end
         end

         if (scan_done) begin
            count_ff <= count_ff - removed_w[TABLE_DEPTH];
         end else if (insert_done) begin
            count_ff <= count_ff + CntW'(1);
         end
      end
   end

   // item key and partial result
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (is_tick) begin
            key_addr_ff <= own_addr_ff;
            key_hb_ff   <= own_hb_ff + HbW'(1);
         end else begin
            key_addr_ff <= req_sender_address;
            key_hb_ff   <= req_message_heartbeat;
         end
         key_now_ff     <= req_current_time;
         key_age_ff     <= is_tick && in_group_now;
         res_reply_ff   <= (req_op == OP_JOIN_REQ);
         res_fwd_ff     <= 1'b0;
         res_drop_ff    <= 1'b0;
         res_removed_ff <= '0;
      end else if (scan_done) begin
         res_removed_ff <= removed_w[TABLE_DEPTH];
         res_fwd_ff     <= flags_w[TABLE_DEPTH].found ? flags_w[TABLE_DEPTH].fresh
                                                      : flags_w[TABLE_DEPTH].free_seen;
         res_drop_ff    <= !flags_w[TABLE_DEPTH].found && !flags_w[TABLE_DEPTH].free_seen;
      end
   end

   // saturate counts to the 7-bit fields
   assign rem_wide = SatW'(res_removed_ff);
   assign cnt_wide = SatW'(count_ff);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_reply_ff   <= res_reply_ff;
         rsp_fwd_ff     <= res_fwd_ff;
         rsp_faddr_ff   <= res_fwd_ff ? key_addr_ff : '0;
         rsp_fhb_ff     <= res_fwd_ff ? key_hb_ff : '0;
         rsp_removed_ff <= (rem_wide > SatW'(CountMax)) ? OutCntW'(CountMax)
                                                        : rem_wide[OutCntW-1:0];
         rsp_drop_ff    <= res_drop_ff;
         rsp_count_ff   <= (cnt_wide > SatW'(CountMax)) ? OutCntW'(CountMax)
                                                        : cnt_wide[OutCntW-1:0];
         rsp_group_ff   <= in_group_now;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_send_join_reply   = rsp_reply_ff;
   assign rsp_forward_valid     = rsp_fwd_ff;
   assign rsp_forward_address   = rsp_faddr_ff;
   assign rsp_forward_heartbeat = rsp_fhb_ff;
   assign rsp_removed_count     = rsp_removed_ff;
   assign rsp_table_full_drop   = rsp_drop_ff;
   assign rsp_member_count      = rsp_count_ff;
   assign rsp_in_group          = rsp_group_ff;

endmodule

// ----- rtl/core/hmt_checker.sv -----
module hmt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_send_join_reply,
   input logic                        rsp_forward_valid,
   input logic [hmt_pkg::AddrW-1:0]   rsp_forward_address,
   input logic [hmt_pkg::HbW-1:0]     rsp_forward_heartbeat,
   input logic [hmt_pkg::OutCntW-1:0] rsp_removed_count,
   input logic                        rsp_table_full_drop
);
   import hmt_pkg::*;

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_forward_address) &&
      $stable(rsp_forward_heartbeat))
      else $error("stalled item changed");

   // no forward means zero address and heartbeat
   a_fwd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_forward_valid |-> rsp_forward_address == '0 &&
      rsp_forward_heartbeat == '0)
      else $error("forward fields not cleared");

   // a dropped member is never forwarded
   a_drop_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full_drop |-> !rsp_forward_valid)
      else $error("drop with forward");

   // a join request never sweeps the table
   a_join_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_join_reply |-> rsp_removed_count == '0)
      else $error("join request removed entries");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item valid after reset");

endmodule

bind heartbeat_membership_table hmt_checker u_hmt_checker (.*);
